// ===== rtl/core/ftpid_pkg.sv =====
// ftpid_pkg: shared types and constants of the fan speed controller
// no dependencies
package ftpid_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 27;

  localparam logic [CfgIdxW-1:0] REG_TEMP_LO         = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TEMP_HI         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP_FAULT_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TEMP_FAULT_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PWM_PERIOD      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CYCLES_PER_UPD  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CLOCK_HZ        = 3'd6;

  localparam logic [15:0] STALE_LIMIT = 16'd40;
  localparam logic [7:0]  TICK_GAP    = 8'd4;
  localparam logic [11:0] RPM_FULL    = 12'd4000;
  localparam logic [11:0] RPM_FLOOR   = 12'd1200;
  localparam logic [11:0] RPM_SPAN    = 12'd2800;
  localparam logic signed [17:0] INTEG_LIMIT = 18'sd50000;
  localparam logic [14:0] RPM_SAT     = 15'd32767;
  localparam logic [4:0]  GAIN_I      = 5'd20;

  typedef struct packed {
    logic        command;
    logic        fan_select;
    logic [15:0] capture_value;
    logic [15:0] update_count;
    logic [7:0]  time_now;
    logic [15:0] temp_a;
    logic [15:0] temp_b;
  } in_item_t;

  typedef struct packed {
    logic        fan_index;
    logic [15:0] duty;
    logic [11:0] target_rpm;
    logic [14:0] measured_rpm;
    logic        overtemp;
  } out_item_t;

endpackage

// ===== rtl/core/ftpid_if.sv =====
// ftpid_if: valid/ready channel carrying one payload of generic type
// no dependencies
interface ftpid_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ftpid_div.sv =====
// ftpid_div: restoring divider, one quotient bit per cycle
// depends on ftpid_pkg
module ftpid_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quo
);
  import ftpid_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] shreg;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dreg;
  logic [CntW-1:0] cnt;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {rem[DenW-1:0], shreg[NumW-1]};
  assign diff  = trial - {1'b0, dreg};
  assign quo   = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(NumW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      rem   <= '0;
      dreg  <= den;
    end else if (busy) begin
      if (!diff[DenW]) begin
        rem   <= diff;
        shreg <= {shreg[NumW-2:0], 1'b1};
      end else begin
        rem   <= trial;
        shreg <= {shreg[NumW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/ftpid_mul.sv =====
// ftpid_mul: shift-add multiplier, one multiplier bit per cycle
// depends on ftpid_pkg
module ftpid_mul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] prod
);
  import ftpid_pkg::*;

  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] areg;
  logic [BW-1:0]    breg;
  logic [CntW-1:0]  cnt;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(BW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      areg <= (AW+BW)'(a);
      breg <= b;
    end else if (busy) begin
      if (breg[0]) acc <= acc + areg;
      areg <= {areg[AW+BW-2:0], 1'b0};
      breg <= {1'b0, breg[BW-1:1]};
    end
  end

endmodule

// ===== rtl/core/fan_tach_pid_speed_controller.sv =====
// Two-fan tach averaging and PID speed controller. A tach edge is handled by
// the 16-bit serial multiply of elapsed updates by cycles_per_update. An
// acting control tick uses a 16-bit serial multiply and a 32-bit serial
// divide for the target, a 32-bit serial divide for RPM and one for the
// integral term, the divides all through the single shared bit-serial
// divider; the target divide is skipped when the hotter temperature lies
// outside the limits or the limits are equal, and the RPM divide when the
// period is zero. One item is in work at a time; a finished result waits in
// the output register while the next item is taken. Quiet ticks and tach
// edges give no result.
// depends on ftpid_pkg, ftpid_if, ftpid_div, ftpid_mul
module fan_tach_pid_speed_controller (
  input  logic                      clk,
  input  logic                      rst,
  ftpid_if.sink                     in_ch,
  ftpid_if.source                   out_ch,
  input  logic                      cfg_we,
  input  logic [ftpid_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ftpid_pkg::CfgDataW-1:0] cfg_data
);
  import ftpid_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_TMUL  = 11'b00000000010,
    S_TFIN  = 11'b00000000100,
    S_TICK  = 11'b00000001000,
    S_TDIV  = 11'b00000010000,
    S_RMUL  = 11'b00000100000,
    S_RDIV  = 11'b00001000000,
    S_PID   = 11'b00010000000,
    S_IDIV  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_t;

  state_t state;

  logic [15:0] temp_lo, temp_hi, temp_fault_low, temp_fault_high;
  logic [15:0] pwm_period, cycles_per_update;
  logic [26:0] clock_hz;

  logic [15:0] tach_last_update [2];
  logic [15:0] tach_last_capture [2];
  logic [31:0] tach_period [2];
  logic signed [17:0] integral_sum [2];
  logic signed [16:0] previous_error [2];
  logic [7:0]  last_tick_time;
  logic        next_fan;
  logic        fault_flag;

  in_item_t    item;
  logic [15:0] temp;
  logic [11:0] target;
  logic [14:0] rpm;
  logic        fan;

  // shared units
  logic        div_start;
  logic        div_busy;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic [31:0] div_quo;
  logic        mul_start;
  logic        mul_busy;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] mul_prod;
  logic        div_sent;
  logic        mul_sent;

  ftpid_div #(.NumW(32), .DenW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  ftpid_mul #(.AW(16), .BW(16)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(mul_prod)
  );

  logic        out_valid;
  out_item_t   out_data;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign in_ch.ready  = (state == S_IDLE);

  // tach datapath
  logic        sel;
  logic [31:0] per;
  logic [31:0] dper;
  logic [31:0] dmag;
  assign sel  = item.fan_select;
  assign per  = mul_prod + 32'(item.capture_value) - 32'(tach_last_capture[sel]);
  assign dper = per - tach_period[sel];
  assign dmag = (~dper) + 32'd1;

  // pid datapath
  logic signed [16:0] err;
  logic signed [18:0] integ_raw;
  logic signed [17:0] integ;
  logic [17:0]        integ_mag;
  logic signed [17:0] deriv;
  logic signed [17:0] iterm;
  logic signed [22:0] outv;
  assign err       = 17'(signed'({5'b0, target})) - 17'(signed'({2'b0, rpm}));
  assign integ_raw = 19'(integral_sum[fan]) + 19'(err);
  assign integ     = (integ_raw > 19'(INTEG_LIMIT)) ? INTEG_LIMIT :
                     (integ_raw < -19'(INTEG_LIMIT)) ? -INTEG_LIMIT : 18'(integ_raw);
  assign integ_mag = integ[17] ? 18'(-integ) : 18'(integ);
  assign deriv     = 18'(err) - 18'(previous_error[fan]);
  assign iterm     = integ[17] ? -18'(div_quo[17:0]) : 18'(div_quo[17:0]);
  assign outv      = 23'(err) * 23'sd2 + 23'(iterm) + 23'(deriv) * 23'sd8
                   + 23'(signed'({1'b0, pwm_period[15:1]}));

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = 32'd1;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TMUL: begin
        mul_start = !mul_sent;
        mul_a = item.update_count - tach_last_update[sel];
        mul_b = cycles_per_update;
      end
      S_TDIV: begin
        div_start = !div_sent;
        div_num = 32'(mul_prod[27:0]);
        div_den = 32'(temp_hi - temp_lo);
        mul_start = 1'b0;
      end
      S_TICK: begin
        mul_start = 1'b1;
        mul_a = 16'(RPM_SPAN);
        mul_b = temp - temp_lo;
      end
      S_RMUL: begin
        div_start = !div_sent;
        div_num = 32'(clock_hz) * 32'd30;
        div_den = tach_period[fan];
      end
      S_RDIV: begin
        div_num = 32'(clock_hz) * 32'd30;
        div_den = tach_period[fan];
      end
      S_IDIV: begin
        div_start = !div_sent;
        div_num = 32'(integ_mag);
        div_den = 32'(GAIN_I);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_lo <= 16'd480;
      temp_hi <= 16'd800;
      temp_fault_low <= 16'd960;
      temp_fault_high <= 16'd1120;
      pwm_period <= 16'd1023;
      cycles_per_update <= 16'd1024;
      clock_hz <= 27'd32000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_LO:         temp_lo <= cfg_data[15:0];
        REG_TEMP_HI:         temp_hi <= cfg_data[15:0];
        REG_TEMP_FAULT_LOW:  temp_fault_low <= cfg_data[15:0];
        REG_TEMP_FAULT_HIGH: temp_fault_high <= cfg_data[15:0];
        REG_PWM_PERIOD:      pwm_period <= cfg_data[15:0];
        REG_CYCLES_PER_UPD:  cycles_per_update <= cfg_data[15:0];
        REG_CLOCK_HZ:        clock_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_sent <= 1'b0;
      mul_sent <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        tach_last_update[i] <= '0;
        tach_last_capture[i] <= '0;
        tach_period[i] <= '0;
        integral_sum[i] <= '0;
        previous_error[i] <= '0;
      end
      last_tick_time <= '0;
      next_fan <= 1'b0;
      fault_flag <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          div_sent <= 1'b0;
          mul_sent <= 1'b0;
          if (in_ch.valid) begin
            item <= in_ch.data;
            state <= in_ch.data.command ? S_TICK : S_TMUL;
            if (in_ch.data.command) begin
              temp <= (in_ch.data.temp_a > in_ch.data.temp_b) ?
                      in_ch.data.temp_a : in_ch.data.temp_b;
            end
          end
        end
        S_TMUL: begin
          mul_sent <= 1'b1;
          if (mul_sent && !mul_busy) state <= S_TFIN;
        end
        S_TFIN: begin
          tach_last_update[sel] <= item.update_count;
          tach_last_capture[sel] <= item.capture_value;
          if (dper[31]) tach_period[sel] <= tach_period[sel] - {1'b0, dmag[31:1]};
          else tach_period[sel] <= tach_period[sel] + {1'b0, dper[31:1]};
          state <= S_IDLE;
        end
        S_TICK: begin
          if (16'(item.update_count - tach_last_update[0]) > STALE_LIMIT) begin
            tach_last_update[0] <= item.update_count;
            tach_last_capture[0] <= '0;
          end
          if (8'(item.time_now - last_tick_time) <= TICK_GAP) begin
            state <= S_IDLE;
          end else begin
            fan <= next_fan;
            next_fan <= ~next_fan;
            last_tick_time <= item.time_now;
            if (fault_flag) begin
              if (temp < temp_fault_low) fault_flag <= 1'b0;
            end else if (temp >= temp_fault_high) begin
              fault_flag <= 1'b1;
            end
            mul_sent <= 1'b1;
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (!mul_busy) begin
            if (temp < temp_lo) begin
              target <= 12'd0;
              state <= S_RMUL;
            end else if (temp > temp_hi) begin
              target <= RPM_FULL;
              state <= S_RMUL;
            end else if (temp_hi == temp_lo) begin
              target <= RPM_FLOOR;
              state <= S_RMUL;
            end else if (!div_sent) begin
              div_sent <= 1'b1;
            end else if (!div_busy) begin
              target <= RPM_FLOOR + div_quo[11:0];
              div_sent <= 1'b0;
              state <= S_RMUL;
            end
          end
        end
        S_RMUL: begin
          if (tach_period[fan] == '0) begin
            rpm <= '0;
            state <= S_PID;
          end else begin
            div_sent <= 1'b1;
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (!div_busy) begin
            rpm <= (div_quo > 32'(RPM_SAT)) ? RPM_SAT : div_quo[14:0];
            div_sent <= 1'b0;
            state <= S_PID;
          end
        end
        S_PID: begin
          state <= S_IDIV;
        end
        S_IDIV: begin
          div_sent <= 1'b1;
          if (div_sent && !div_busy) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            integral_sum[fan] <= integ;
            previous_error[fan] <= err;
            out_valid <= 1'b1;
            out_data.fan_index <= fan;
            out_data.duty <= outv < 0 ? 16'd0 :
                             (outv > 23'(signed'({1'b0, pwm_period}))) ? pwm_period :
                             outv[15:0];
            out_data.target_rpm <= target;
            out_data.measured_rpm <= rpm;
            out_data.overtemp <= fault_flag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_busy || !div_sent) else $error("divider busy in idle");
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.target_rpm <= RPM_FULL) else $error("target out of range");
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_data.duty <= pwm_period) else $error("duty over period");

endmodule

// ===== dv/ftpid_tb_if.sv =====
// ftpid_tb_if: testbench clock generator, 4 ns period
// no dependencies
module ftpid_tb_clkgen (output logic clk);
  timeunit 1ns;
  timeprecision 1ps;
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end
endmodule

// ===== dv/fan_tach_pid_speed_controller_test.sv =====
// fan_tach_pid_speed_controller_test: drives tach edges and control ticks,
// predicts each duty update in a local model and compares every transfer
// depends on ftpid_pkg, ftpid_if, ftpid_tb_clkgen, fan_tach_pid_speed_controller
module fan_tach_pid_speed_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ftpid_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ftpid_tb_clkgen clkgen (.clk(clk));
  ftpid_if #(.payload_t(in_item_t)) in_ch ();
  ftpid_if #(.payload_t(out_item_t)) out_ch ();

  fan_tach_pid_speed_controller dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller model state
  logic [15:0] t_min, t_max, f_low, f_high, pwm_per, cyc_upd;
  logic [26:0] clk_hz;
  logic [15:0] last_upd [2];
  logic [15:0] last_cap [2];
  logic [31:0] period [2];
  int integ_acc [2];
  int prev_err [2];
  logic [7:0] last_tick;
  logic nxt_fan;
  logic fault;

  out_item_t duty_q[$];
  int errors = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len = 0;
  int hold_done = 0;

  task automatic model_reset();
    t_min = 480; t_max = 800; f_low = 960; f_high = 1120;
    pwm_per = 1023; cyc_upd = 1024; clk_hz = 27'd32000000;
    for (int i = 0; i < 2; i++) begin
      last_upd[i] = 0; last_cap[i] = 0; period[i] = 0;
      integ_acc[i] = 0; prev_err[i] = 0;
    end
    last_tick = 0; nxt_fan = 0; fault = 0;
  endtask

  function automatic logic [14:0] rpm_of_period(logic [31:0] p);
    longint unsigned r;
    if (p == 0) return 15'd0;
    r = (longint'(clk_hz) * 30) / longint'(p);
    return (r > 32767) ? 15'd32767 : r[14:0];
  endfunction

  task automatic predict_controller(in_item_t it);
    logic [15:0] el;
    logic [31:0] per, d;
    logic [15:0] temp;
    int target, rpm, err, integ, deriv;
    longint outv;
    logic f;
    out_item_t r;
    if (!it.command) begin
      el = it.update_count - last_upd[it.fan_select];
      per = 32'(el) * 32'(cyc_upd) + 32'(it.capture_value) - 32'(last_cap[it.fan_select]);
      d = per - period[it.fan_select];
      last_upd[it.fan_select] = it.update_count;
      last_cap[it.fan_select] = it.capture_value;
      if (d[31]) period[it.fan_select] -= ((~d) + 32'd1) >> 1;
      else period[it.fan_select] += d >> 1;
      return;
    end
    if (16'(it.update_count - last_upd[0]) > 16'd40) begin
      last_upd[0] = it.update_count;
      last_cap[0] = 0;
    end
    if (8'(it.time_now - last_tick) <= 8'd4) return;
    temp = (it.temp_a > it.temp_b) ? it.temp_a : it.temp_b;
    if (temp < t_min) target = 0;
    else if (temp > t_max) target = 4000;
    else if (t_max == t_min) target = 1200;
    else target = 1200 + (2800 * (int'(temp) - int'(t_min))) / (int'(t_max) - int'(t_min));
    if (fault) begin
      if (temp < f_low) fault = 0;
    end else if (temp >= f_high) fault = 1;
    last_tick = it.time_now;
    f = nxt_fan;
    nxt_fan = ~nxt_fan;
    rpm = rpm_of_period(period[f]);
    err = target - rpm;
    integ = integ_acc[f] + err;
    if (integ > 50000) integ = 50000;
    if (integ < -50000) integ = -50000;
    integ_acc[f] = integ;
    deriv = err - prev_err[f];
    prev_err[f] = err;
    outv = longint'(err) * 2 + longint'(integ / 20) + longint'(deriv) * 8
         + longint'(pwm_per / 2);
    if (outv < 0) outv = 0;
    if (outv > longint'(pwm_per)) outv = pwm_per;
    r.fan_index = f;
    r.duty = outv[15:0];
    r.target_rpm = target[11:0];
    r.measured_rpm = rpm[14:0];
    r.overtemp = fault;
    duty_q.push_back(r);
  endtask

  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_controller(it);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_len > hold_done) begin
      out_ch.ready <= 1'b0;
      hold_done <= hold_done + 1;
    end else out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (duty_q.size() == 0) begin
        $error("unexpected result transfer %p", out_ch.data);
        errors++;
      end else begin
        out_item_t e;
        e = duty_q.pop_front();
        if (out_ch.data.fan_index !== e.fan_index) begin
          $error("fan_index exp %0d got %0d", e.fan_index, out_ch.data.fan_index); errors++;
        end
        if (out_ch.data.duty !== e.duty) begin
          $error("duty exp %0d got %0d", e.duty, out_ch.data.duty); errors++;
        end
        if (out_ch.data.target_rpm !== e.target_rpm) begin
          $error("target_rpm exp %0d got %0d", e.target_rpm, out_ch.data.target_rpm); errors++;
        end
        if (out_ch.data.measured_rpm !== e.measured_rpm) begin
          $error("measured_rpm exp %0d got %0d", e.measured_rpm, out_ch.data.measured_rpm);
          errors++;
        end
        if (out_ch.data.overtemp !== e.overtemp) begin
          $error("overtemp exp %0d got %0d", e.overtemp, out_ch.data.overtemp); errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_TEMP_LO: t_min = val[15:0];
      REG_TEMP_HI: t_max = val[15:0];
      REG_TEMP_FAULT_LOW: f_low = val[15:0];
      REG_TEMP_FAULT_HIGH: f_high = val[15:0];
      REG_PWM_PERIOD: pwm_per = val[15:0];
      REG_CYCLES_PER_UPD: cyc_upd = val[15:0];
      REG_CLOCK_HZ: clk_hz = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t tach_item(logic fan, logic [15:0] cap, logic [15:0] upd);
    in_item_t it;
    it = '0;
    it.fan_select = fan;
    it.capture_value = cap;
    it.update_count = upd;
    it.time_now = 8'($urandom);
    it.temp_a = 16'($urandom);
    it.temp_b = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [15:0] upd, logic [7:0] tn,
                                         logic [15:0] ta, logic [15:0] tb);
    in_item_t it;
    it = '0;
    it.command = 1'b1;
    it.fan_select = 1'($urandom);
    it.capture_value = 16'($urandom);
    it.update_count = upd;
    it.time_now = tn;
    it.temp_a = ta;
    it.temp_b = tb;
    return it;
  endfunction

  logic [15:0] upd_now;
  logic [7:0] time_cur;

  task automatic test_directed();
    send_item(tick_item(0, 5, 0, 0));
    send_item(tick_item(0, 6, 1000, 0));
    send_item(tach_item(0, 16'hffff, 16'd3));
    send_item(tach_item(1, 16'd0, 16'hffff));
    send_item(tach_item(0, 16'd100, 16'd4));
    send_item(tach_item(1, 16'd500, 16'd1));
    send_item(tick_item(4, 12, 16'hffff, 0));
    send_item(tick_item(4, 20, 0, 16'hffff));
    send_item(tick_item(4, 30, 640, 500));
    send_item(tick_item(4, 40, 700, 965));
    send_item(tick_item(4, 50, 950, 10));
    send_item(tick_item(16'd100, 60, 479, 480));
    send_item(tach_item(0, 16'd7, 16'd101));
    send_item(tick_item(16'd101, 255, 1120, 0));
    send_item(tick_item(16'd101, 3, 800, 0));
    wait_idle();
    write_reg(REG_TEMP_LO, 600);
    write_reg(REG_TEMP_HI, 600);
    write_reg(REG_PWM_PERIOD, 0);
    write_reg(REG_SPARE, 27'h5a5);
    send_item(tick_item(16'd101, 10, 600, 600));
    send_item(tick_item(16'd101, 20, 599, 0));
    send_item(tick_item(16'd101, 30, 601, 0));
    wait_idle();
    upd_now = 16'd101;
    time_cur = 8'd30;
  endtask

  task automatic run_random(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_item(tach_item(1'($urandom), 16'($urandom), 16'($urandom)));
        1: send_item(tick_item(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)));
        2, 3, 4: begin
          upd_now = upd_now + 16'($urandom_range(3));
          send_item(tach_item(1'($urandom), 16'($urandom), upd_now));
        end
        default: begin
          upd_now = upd_now + 16'($urandom_range(2));
          time_cur = time_cur + 8'(($urandom_range(3) == 0) ? $urandom_range(4) :
                                   $urandom_range(5, 40));
          it = tick_item(upd_now, time_cur,
                         16'($urandom_range(t_min > 100 ? t_min - 100 : 0,
                                            32'(f_high) + 100)), 16'($urandom));
          if ($urandom_range(1)) it.temp_b = 16'($urandom_range(1200));
          send_item(it);
        end
      endcase
    end
  endtask

  task automatic set_regs(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d,
                          logic [15:0] p, logic [15:0] cu, logic [26:0] hz);
    write_reg(REG_TEMP_LO, 27'(a));
    write_reg(REG_TEMP_HI, 27'(b));
    write_reg(REG_TEMP_FAULT_LOW, 27'(c));
    write_reg(REG_TEMP_FAULT_HIGH, 27'(d));
    write_reg(REG_PWM_PERIOD, 27'(p));
    write_reg(REG_CYCLES_PER_UPD, 27'(cu));
    write_reg(REG_CLOCK_HZ, hz);
  endtask

  task automatic test_random_defaults();
    set_regs(480, 800, 960, 1120, 1023, 1024, 27'd32000000);
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(250);
    wait_idle();
  endtask

  task automatic test_random_extremes();
    set_regs(0, 16'hffff, 0, 16'hffff, 16'hffff, 1, 27'h7ffffff);
    send_idle_pct = 48; recv_stall_pct = 0;
    run_random(250);
    wait_idle();
    set_regs(16'hffff, 16'hffff, 16'hffff, 0, 1, 16'hffff, 27'd1);
    send_idle_pct = 0; recv_stall_pct = 48;
    run_random(250);
    wait_idle();
  endtask

  task automatic test_random_mixed();
    set_regs(300, 900, 700, 1000, 2000, 300, 27'd1000000);
    send_idle_pct = 22; recv_stall_pct = 22;
    run_random(400);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_regs(400, 1000, 900, 1100, 500, 2048, 27'd8000000);
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_len += 3000;
    run_random(280);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    model_reset();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_defaults();
    test_random_extremes();
    test_random_mixed();
    test_backpressure();
    if (errors == 0 && duty_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== fan_tach_pid_speed_controller.f =====
rtl/core/ftpid_pkg.sv
rtl/core/ftpid_if.sv
rtl/core/ftpid_div.sv
rtl/core/ftpid_mul.sv
rtl/core/fan_tach_pid_speed_controller.sv
dv/ftpid_tb_if.sv
dv/fan_tach_pid_speed_controller_test.sv
